// File: rtl/core/vlmac_pkg.sv
// Shared types, constants and opcode encodings for the lane multiply-accumulate core.
`timescale 1ns / 1ps

package vlmac_pkg;

  // Field widths
  localparam int unsigned OP_W      = 4;
  localparam int unsigned LANE_W    = 3;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned S_TDATA_W = 40;  // 39 bits of fields, padded to bytes
  localparam int unsigned M_TDATA_W = 64;

  // Default lane count
  localparam int unsigned LANES_DEF = 8;

  // Rounding constant loaded with the fractional multiplies
  localparam logic [ACC_W-1:0] ROUND_K = 48'h0000_0000_8000;

  // Opcodes
  typedef enum logic [OP_W-1:0] {
    OP_MULF = 4'd0,
    OP_MULU = 4'd1,
    OP_MUDL = 4'd2,
    OP_MUDM = 4'd3,
    OP_MUDN = 4'd4,
    OP_MUDH = 4'd5,
    OP_MACF = 4'd6,
    OP_MACU = 4'd7,
    OP_MADL = 4'd8,
    OP_MADM = 4'd9,
    OP_MADN = 4'd10,
    OP_MADH = 4'd11
  } op_e;

  // How the destination element is taken from the accumulator
  typedef enum logic [2:0] {
    RES_SIGNED,
    RES_UNSIGNED,
    RES_LOW_CLAMP,
    RES_LOW,
    RES_MID,
    RES_ZERO
  } res_mode_e;

  // Control that travels with the product into the accumulate stage
  typedef struct packed {
    logic      load;  // overwrite rather than add
    logic      rnd;   // add the rounding constant on load
    res_mode_e mode;
  } acc_ctl_t;

endpackage

// File: rtl/core/vlmac_mul.sv
// Operation decode and 17x17 signed multiply, combinational.
`timescale 1ns / 1ps

module vlmac_mul (
  input  logic [vlmac_pkg::OP_W-1:0]      op_i,
  input  logic [vlmac_pkg::DATA_W-1:0]    src_s_i,
  input  logic [vlmac_pkg::DATA_W-1:0]    src_t_i,
  // to the accumulate stage
  output vlmac_pkg::acc_ctl_t             ctl_o,
  output logic [vlmac_pkg::ACC_W-1:0]     prod_o
);

  logic                          s_sgn;
  logic                          t_sgn;
  logic signed [16:0]            sx;
  logic signed [16:0]            tx;
  logic signed [33:0]            p;

  // Opcode decode: source signedness, product form, load/add, result mode
  always_comb begin
    s_sgn  = 1'b1;
    t_sgn  = 1'b1;
    ctl_o  = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_ZERO};
    sx     = $signed({s_sgn & src_s_i[15], src_s_i});
    tx     = $signed({t_sgn & src_t_i[15], src_t_i});
    p      = sx * tx;
    prod_o = '0;
    case (vlmac_pkg::op_e'(op_i))
      vlmac_pkg::OP_MULF, vlmac_pkg::OP_MULU, vlmac_pkg::OP_MACF, vlmac_pkg::OP_MACU: begin
        prod_o = {{13{p[33]}}, p, 1'b0};
      end
      vlmac_pkg::OP_MUDL, vlmac_pkg::OP_MADL: begin
        s_sgn  = 1'b0;
        t_sgn  = 1'b0;
        sx     = $signed({s_sgn & src_s_i[15], src_s_i});
        tx     = $signed({t_sgn & src_t_i[15], src_t_i});
        p      = sx * tx;
        prod_o = {32'h0, p[31:16]};
      end
      vlmac_pkg::OP_MUDM, vlmac_pkg::OP_MADM: begin
        t_sgn  = 1'b0;
        tx     = $signed({t_sgn & src_t_i[15], src_t_i});
        p      = sx * tx;
        prod_o = {{14{p[33]}}, p};
      end
      vlmac_pkg::OP_MUDN, vlmac_pkg::OP_MADN: begin
        s_sgn  = 1'b0;
        sx     = $signed({s_sgn & src_s_i[15], src_s_i});
        p      = sx * tx;
        prod_o = {{14{p[33]}}, p};
      end
      vlmac_pkg::OP_MUDH, vlmac_pkg::OP_MADH: begin
        prod_o = {p[31:0], 16'h0};
      end
      default: begin
        prod_o = '0;
      end
    endcase

    case (vlmac_pkg::op_e'(op_i))
      vlmac_pkg::OP_MULF: ctl_o = '{load: 1'b1, rnd: 1'b1, mode: vlmac_pkg::RES_SIGNED};
      vlmac_pkg::OP_MULU: ctl_o = '{load: 1'b1, rnd: 1'b1, mode: vlmac_pkg::RES_UNSIGNED};
      vlmac_pkg::OP_MUDL: ctl_o = '{load: 1'b1, rnd: 1'b0, mode: vlmac_pkg::RES_LOW};
      vlmac_pkg::OP_MUDM: ctl_o = '{load: 1'b1, rnd: 1'b0, mode: vlmac_pkg::RES_MID};
      vlmac_pkg::OP_MUDN: ctl_o = '{load: 1'b1, rnd: 1'b0, mode: vlmac_pkg::RES_LOW};
      vlmac_pkg::OP_MUDH: ctl_o = '{load: 1'b1, rnd: 1'b0, mode: vlmac_pkg::RES_SIGNED};
      vlmac_pkg::OP_MACF: ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_SIGNED};
      vlmac_pkg::OP_MACU: ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_UNSIGNED};
      vlmac_pkg::OP_MADL: ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_LOW_CLAMP};
      vlmac_pkg::OP_MADM: ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_SIGNED};
      vlmac_pkg::OP_MADN: ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_LOW_CLAMP};
      vlmac_pkg::OP_MADH: ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_SIGNED};
      // unused opcode: add zero, leave the lane as it is, result zero
      default:            ctl_o = '{load: 1'b0, rnd: 1'b0, mode: vlmac_pkg::RES_ZERO};
    endcase
  end

endmodule

// File: rtl/core/vlmac_acc.sv
// Accumulate stage: lane accumulator bank, 48-bit add, clamp/select, output register.
`timescale 1ns / 1ps

module vlmac_acc #(
  parameter int unsigned LANES = vlmac_pkg::LANES_DEF,
  localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // from the multiply stage
  input  logic                            valid_i,
  output logic                            ready_o,
  input  vlmac_pkg::acc_ctl_t             ctl_i,
  input  logic [IDX_W-1:0]                idx_i,
  input  logic [vlmac_pkg::ACC_W-1:0]     prod_i,
  // result register
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [vlmac_pkg::DATA_W-1:0]    result_o,
  output logic [vlmac_pkg::ACC_W-1:0]     acc_o
);

  logic [vlmac_pkg::ACC_W-1:0]  acc_q [LANES];
  logic [vlmac_pkg::ACC_W-1:0]  base;
  logic [vlmac_pkg::ACC_W-1:0]  sum;
  logic                         in_range;
  logic                         neg;
  logic [vlmac_pkg::DATA_W-1:0] res_d;
  logic                         fire;

  logic                         valid_q;
  logic [vlmac_pkg::DATA_W-1:0] res_q;
  logic [vlmac_pkg::ACC_W-1:0]  sum_q;

  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;

  // Load or accumulate
  always_comb begin
    if (ctl_i.load) begin
      base = ctl_i.rnd ? vlmac_pkg::ROUND_K : '0;
    end else begin
      base = acc_q[idx_i];
    end
    sum = base + prod_i;
  end

  // acc[47:16] fits in 16 signed bits when bits 47..31 agree
  assign neg      = sum[47];
  assign in_range = (sum[47:31] == '0) || (sum[47:31] == '1);

  // Destination element
  always_comb begin
    case (ctl_i.mode)
      vlmac_pkg::RES_SIGNED: begin
        res_d = in_range ? sum[31:16] : (neg ? 16'h8000 : 16'h7FFF);
      end
      vlmac_pkg::RES_UNSIGNED: begin
        if (neg) begin
          res_d = '0;
        end else if (|sum[46:31]) begin
          res_d = 16'hFFFF;
        end else begin
          res_d = sum[31:16];
        end
      end
      vlmac_pkg::RES_LOW_CLAMP: begin
        res_d = in_range ? sum[15:0] : (neg ? 16'h0000 : 16'hFFFF);
      end
      vlmac_pkg::RES_LOW: res_d = sum[15:0];
      vlmac_pkg::RES_MID: res_d = sum[31:16];
      default:            res_d = '0;
    endcase
  end

  // Lane accumulators, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (fire) begin
      acc_q[idx_i] <= sum;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
      sum_q <= sum;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;
  assign acc_o    = sum_q;

endmodule

// File: rtl/core/vector_lane_multiply_accumulate_core.sv
// Top level of the per-lane vector multiply-accumulate element core.
//
// Use: one element operation per slave transaction. s_axis_tdata carries the
// opcode, the lane number and the two 16-bit sources. Each transaction yields
// exactly one master transaction with the destination element and the three
// 16-bit words of the lane accumulator after the operation.
// Pipeline: input register, then decode, multiply, lane accumulate and
// clamp/select as one combinational pass into the output register, which
// drives m_axis.
// Throughput: one transaction per cycle while m_axis_tready stays high, also for
// back-to-back operations on the same lane, since the read, add and write-back
// of an accumulator happen in the same pass.
// Lane numbers at or above LANES wrap modulo LANES.
// Reset: all lane accumulators clear to zero and the pipeline empties.
// Stall: when m_axis_tready is low the held result stays stable; the input
// register still fills, so up to two transactions are taken before
// s_axis_tready drops.
`timescale 1ns / 1ps

module vector_lane_multiply_accumulate_core #(
  parameter int unsigned LANES = vlmac_pkg::LANES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // element operation in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [3:0] op, [6:4] lane, [22:7] src_s, [38:23] src_t, [39] zero
  input  logic [vlmac_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // element result out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] result, [31:16] acc_high, [47:32] acc_mid, [63:48] acc_low
  output logic [vlmac_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned LANE_N = 2 ** vlmac_pkg::LANE_W;

  logic [IDX_W-1:0]                  wrap_tbl [LANE_N];
  logic [vlmac_pkg::LANE_W-1:0]      lane_in;

  logic                              in_valid_q;
  logic [vlmac_pkg::OP_W-1:0]        op_q;
  logic [IDX_W-1:0]                  idx_q;
  logic [vlmac_pkg::DATA_W-1:0]      src_s_q;
  logic [vlmac_pkg::DATA_W-1:0]      src_t_q;

  logic                              acc_ready;
  vlmac_pkg::acc_ctl_t               p_ctl;
  logic [vlmac_pkg::ACC_W-1:0]       p_prod;

  logic [vlmac_pkg::DATA_W-1:0]      result;
  logic [vlmac_pkg::ACC_W-1:0]       acc;

  // Lane number to accumulator index, modulo LANES
  for (genvar g = 0; g < LANE_N; g++) begin : g_wrap
    localparam int unsigned WRAPPED = g % LANES;
    assign wrap_tbl[g] = IDX_W'(WRAPPED);
  end

  assign lane_in       = s_axis_tdata[6:4];
  assign s_axis_tready = !in_valid_q || acc_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q    <= s_axis_tdata[3:0];
      idx_q   <= wrap_tbl[lane_in];
      src_s_q <= s_axis_tdata[22:7];
      src_t_q <= s_axis_tdata[38:23];
    end
  end

  // Decode and multiply
  vlmac_mul u_mul (
    .op_i    (op_q),
    .src_s_i (src_s_q),
    .src_t_i (src_t_q),
    .ctl_o   (p_ctl),
    .prod_o  (p_prod)
  );

  // Accumulate stage and output register
  vlmac_acc #(
    .LANES (LANES)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .ready_o  (acc_ready),
    .ctl_i    (p_ctl),
    .idx_i    (idx_q),
    .prod_i   (p_prod),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result),
    .acc_o    (acc)
  );

  assign m_axis_tdata = {acc[15:0], acc[31:16], acc[47:32], result};

endmodule

// File: tb/sv/tb_vector_lane_multiply_accumulate_core.sv
// Self-checking stream testbench for the lane multiply-accumulate core.
`timescale 1ns / 1ps

module tb_vector_lane_multiply_accumulate_core;
  import vlmac_pkg::*;

  localparam int unsigned LANES          = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // idle cycles before giving up
  localparam int unsigned DRAIN_CYCLES   = 10;    // pipeline is two deep
  localparam int unsigned HOLDOFF_CYCLES = 60;
  localparam int unsigned MAX_REPORTS    = 10;

  // Destination element plus accumulator words, laid out as on m_axis_tdata
  typedef struct packed {
    logic [15:0] acc_low;
    logic [15:0] acc_mid;
    logic [15:0] acc_high;
    logic [15:0] result;
  } elem_res_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state and expected results in arrival order
  logic [ACC_W-1:0] lane_acc [LANES];
  elem_res_t        elem_exp_q [$];

  int err_cnt;
  int burst_left;
  int gap_max;
  int holdoff_req;

  vector_lane_multiply_accumulate_core #(
    .LANES(LANES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Element operation: load or add the product, then clamp or select the result
  function automatic elem_res_t mac_predict(input logic [3:0] op, input logic [2:0] lane,
                                            input logic [15:0] s_u, input logic [15:0] t_u);
    logic signed [63:0] s_sx;
    logic signed [63:0] t_sx;
    logic signed [63:0] s_zx;
    logic signed [63:0] t_zx;
    logic signed [63:0] prod;
    logic [ACC_W-1:0]   acc;
    logic signed [31:0] hi;
    logic [3:0]         kind;
    elem_res_t          r;
    s_sx = $signed(s_u);
    t_sx = $signed(t_u);
    s_zx = {48'd0, s_u};
    t_zx = {48'd0, t_u};
    acc  = lane_acc[lane % LANES];
    r    = '0;
    if (op <= OP_MADH) begin
      kind = (op < OP_MACF) ? op : op - OP_MACF;
      case (kind)
        OP_MULF, OP_MULU: begin
          prod = 2 * s_sx * t_sx;
          if (op < OP_MACF) prod = prod + ROUND_K;
        end
        OP_MUDL: prod = (s_zx * t_zx) >>> 16;
        OP_MUDM: prod = s_sx * t_zx;
        OP_MUDN: prod = s_zx * t_sx;
        default: prod = (s_sx * t_sx) <<< 16;
      endcase
      acc = (op < OP_MACF) ? prod[ACC_W-1:0] : acc + prod[ACC_W-1:0];
      lane_acc[lane % LANES] = acc;
      hi = acc[47:16];
      case (op)
        OP_MULU, OP_MACU: begin
          if (hi < 0)               r.result = 16'h0000;
          else if (hi > 32'sh7FFF)  r.result = 16'hFFFF;
          else                      r.result = acc[31:16];
        end
        OP_MUDL, OP_MUDN: r.result = acc[15:0];
        OP_MUDM:          r.result = acc[31:16];
        OP_MADL, OP_MADN: begin
          if (hi < -32768)          r.result = 16'h0000;
          else if (hi > 32767)      r.result = 16'hFFFF;
          else                      r.result = acc[15:0];
        end
        default: begin
          if (hi < -32768)          r.result = 16'h8000;
          else if (hi > 32767)      r.result = 16'h7FFF;
          else                      r.result = acc[31:16];
        end
      endcase
    end
    r.acc_high = acc[47:32];
    r.acc_mid  = acc[31:16];
    r.acc_low  = acc[15:0];
    return r;
  endfunction

  task automatic report_err(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Push one element transaction; bursts with random gaps in between
  task automatic send_elem(input logic [3:0] op, input logic [2:0] lane,
                           input logic [15:0] src_s, input logic [15:0] src_t);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, src_t, src_s, lane, op};
    do @(posedge clk_i); while (!s_axis_tready);
    elem_exp_q.push_back(mac_predict(op, lane, src_s, src_t));
    burst_left--;
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (elem_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Extremes and small values a third of the time, the rest full range
  function automatic logic [15:0] rand_src();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      1:       return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Accumulates dominate, loads are less common, a few unused opcodes
  function automatic logic [3:0] rand_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2)  return 4'($urandom_range(int'(OP_MADH) + 1, (1 << OP_W) - 1));
    if (sel < 20) return 4'($urandom_range(int'(OP_MULF), int'(OP_MUDH)));
    return 4'($urandom_range(int'(OP_MACF), int'(OP_MADH)));
  endfunction

  task automatic send_random(input int n);
    logic [2:0] lane;
    lane = 3'($urandom_range(0, LANES - 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) lane = 3'($urandom_range(0, LANES - 1));
      send_elem(rand_op(), lane, rand_src(), rand_src());
    end
  endtask

  // Saturation, clamps, word selects, wrap of the accumulator, unused opcodes
  task automatic test_directed();
    gap_max = 2;
    send_elem(OP_MULF, 3'd0, 16'h8000, 16'h8000);
    send_elem(OP_MULF, 3'd0, 16'h7FFF, 16'h8000);
    send_elem(OP_MULU, 3'd0, 16'h8000, 16'h7FFF);
    send_elem(OP_MULU, 3'd0, 16'h7FFF, 16'h7FFF);
    send_elem(OP_MULU, 3'd0, 16'h0040, 16'h0100);
    send_elem(OP_MUDL, 3'd0, 16'hFFFF, 16'hFFFF);
    send_elem(OP_MUDM, 3'd0, 16'hFFFF, 16'hFFFF);
    send_elem(OP_MUDN, 3'd0, 16'hFFFF, 16'h8000);
    send_elem(OP_MUDH, 3'd0, 16'h8000, 16'h8000);
    send_elem(OP_MUDH, 3'd0, 16'h7FFF, 16'h8000);
    // accumulate up into positive saturation, then pull back
    send_elem(OP_MULF, 3'd1, 16'h0000, 16'h0000);
    repeat (3) send_elem(OP_MACF, 3'd1, 16'h7FFF, 16'h7FFF);
    send_elem(OP_MACU, 3'd1, 16'h8000, 16'h7FFF);
    send_elem(OP_MUDL, 3'd2, 16'h1234, 16'h5678);
    send_elem(OP_MADL, 3'd2, 16'hFFFF, 16'hFFFF);
    send_elem(OP_MADM, 3'd2, 16'h8000, 16'hFFFF);
    send_elem(OP_MADN, 3'd2, 16'hFFFF, 16'h7FFF);
    send_elem(OP_MADH, 3'd2, 16'h7FFF, 16'h7FFF);
    // four steps of 2^46 wrap the accumulator back to zero
    send_elem(OP_MUDH, 3'd7, 16'h8000, 16'h8000);
    repeat (3) send_elem(OP_MADH, 3'd7, 16'h8000, 16'h8000);
    // unused opcodes leave the accumulator alone and return zero
    for (int u = int'(OP_MADH) + 1; u < (1 << OP_W); u++)
      send_elem(4'(u), 3'd1, 16'hFFFF, 16'h8000);
    wait_drained();
  endtask

  // Receiver holds off long enough for the input side to back up
  task automatic test_output_holdoff();
    gap_max     = 0;
    holdoff_req = HOLDOFF_CYCLES;
    send_random(40);
    wait_drained();
  endtask

  // Random stream in chunks, each with its own sender gap profile
  task automatic test_random_stream(input int n);
    int gaps [3] = '{0, 3, 12};
    for (int done = 0; done < n; done += 100) begin
      gap_max = gaps[$urandom_range(0, 2)];
      send_random((n - done < 100) ? n - done : 100);
    end
    wait_drained();
  endtask

  // Sender pauses for a full drain in the middle of a stream
  task automatic test_drain_and_resume();
    gap_max = 3;
    send_random(80);
    wait_drained();
    send_random(80);
    wait_drained();
  endtask

  // Receiver stall pattern, plus long hold-off on request
  initial begin : rx_stall_gen
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       phase;
    m_axis_tready = 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req > 0) begin
        hold_left   = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left <= 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
          default:   m_axis_tready <= ((phase % 7) < 4);
        endcase
      end
    end
  end

  // Result checker: every accepted transaction against the oldest expectation
  initial begin : result_check
    elem_res_t got;
    elem_res_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got = m_axis_tdata;
        if (elem_exp_q.size() == 0) begin
          report_err($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = elem_exp_q.pop_front();
          if (got.result !== want.result)
            report_err($sformatf("result exp %h got %h", want.result, got.result));
          if (got.acc_high !== want.acc_high)
            report_err($sformatf("acc_high exp %h got %h", want.acc_high, got.acc_high));
          if (got.acc_mid !== want.acc_mid)
            report_err($sformatf("acc_mid exp %h got %h", want.acc_mid, got.acc_mid));
          if (got.acc_low !== want.acc_low)
            report_err($sformatf("acc_low exp %h got %h", want.acc_low, got.acc_low));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : idle_watchdog
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid === 1'b1 && m_axis_tready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_cnt       = 0;
    burst_left    = 0;
    gap_max       = 0;
    holdoff_req   = 0;
    for (int i = 0; i < LANES; i++) lane_acc[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_output_holdoff();
    test_random_stream(1450);
    test_drain_and_resume();

    if (elem_exp_q.size() != 0)
      report_err($sformatf("%0d results never arrived", elem_exp_q.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
